@@ src/dpid_pkg.sv @@
// shared constants for the discrete pid core with filtered derivative
`default_nettype none

package dpid_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int DB_W   = 31;
  localparam int CFG_AW = 3;
  localparam int ACC_W  = 68;

  localparam logic [CFG_AW-1:0] REG_COEF_OUT1 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COEF_OUT2 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEF_ERR0 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEF_ERR1 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COEF_ERR2 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OUT_MIN   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_OUT_MAX   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DEAD_BAND = 3'd7;

  localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = -32'sd655360;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 32'sd655360;

endpackage

`default_nettype wire

@@ src/discrete_pid_filtered_derivative_core.sv @@
// top level of the discrete pid core with filtered derivative
// One sample transaction is taken per clock cycle while the output is not stalled; its
// result is registered first in the input register, then in the result register. The path
// between the two registers holds five parallel 32x32 signed multipliers, a 68-bit sum,
// round-to-nearest, saturation and the min/max clamp; that path sets the clock rate. A
// transaction with the clear flag set zeroes the error and output history, leaves the input
// register without waiting for the output and produces no result. Other samples hold the
// input register while a result waits; a new sample is then accepted only if it is empty.
`default_nettype none

module discrete_pid_filtered_derivative_core
  import dpid_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_AW-1:0]   cfg_addr,
  input  wire logic [DATA_W-1:0]   cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [2*DATA_W-1:0] s_tdata,   // measurement, target
  input  wire logic                s_tuser,   // clear
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [2*DATA_W-1:0]      m_tdata,   // drive, raw_value
  output logic                     m_tuser    // clamped
);

  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic signed [DATA_W-1:0] coef_out1, coef_out2, coef_err0, coef_err1, coef_err2;
  logic signed [DATA_W-1:0] out_min, out_max;
  logic [DB_W-1:0]          dead_band;

  logic signed [DATA_W-1:0] err_prev, err_prev2, raw_prev, raw_prev2;

  logic                     in_valid;
  logic                     in_clear;
  logic signed [DATA_W-1:0] in_meas, in_targ;

  logic signed [DATA_W-1:0] drive, raw_value;
  logic                     clamped;

  logic                     fire;
  logic signed [DATA_W+1:0] diff;
  logic [DATA_W+1:0]        mag;
  logic signed [DATA_W:0]   diff_db;
  logic signed [DATA_W-1:0] err;
  logic signed [2*DATA_W-1:0] p_o1, p_o2, p_e0, p_e1, p_e2;
  logic signed [ACC_W-1:0]  acc, total, quot;
  logic signed [DATA_W-1:0] raw_next, drive_next;

  assign fire     = in_valid && (in_clear || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  assign m_tdata = {raw_value, drive};
  assign m_tuser = clamped;

  always_comb begin
    diff    = (DATA_W+2)'(in_targ) - (DATA_W+2)'(in_meas);
    mag     = diff[DATA_W+1] ? unsigned'(-diff) : unsigned'(diff);
    diff_db = (mag < (DATA_W+2)'(dead_band)) ? '0 : diff[DATA_W:0];
    if (diff_db[DATA_W] == diff_db[DATA_W-1]) begin
      err = diff_db[DATA_W-1:0];
    end else if (diff_db[DATA_W]) begin
      err = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      err = {1'b0, {(DATA_W-1){1'b1}}};
    end

    p_o1 = coef_out1 * raw_prev;
    p_o2 = coef_out2 * raw_prev2;
    p_e0 = coef_err0 * err;
    p_e1 = coef_err1 * err_prev;
    p_e2 = coef_err2 * err_prev2;

    acc   = ACC_W'(p_e0) + ACC_W'(p_e1) + ACC_W'(p_e2) - ACC_W'(p_o1) - ACC_W'(p_o2);
    total = acc + $signed(HALF);
    quot  = total >>> FRAC_BITS;

    if (quot[ACC_W-1:DATA_W-1] == '0 || quot[ACC_W-1:DATA_W-1] == '1) begin
      raw_next = quot[DATA_W-1:0];
    end else if (quot[ACC_W-1]) begin
      raw_next = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      raw_next = {1'b0, {(DATA_W-1){1'b1}}};
    end

    drive_next = raw_next;
    if (raw_next > out_max) begin
      drive_next = out_max;
    end
    if (raw_next < out_min) begin
      drive_next = out_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_out1 <= '0;
      coef_out2 <= '0;
      coef_err0 <= '0;
      coef_err1 <= '0;
      coef_err2 <= '0;
      out_min   <= OUT_MIN_RESET;
      out_max   <= OUT_MAX_RESET;
      dead_band <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_OUT1: coef_out1 <= cfg_data;
        REG_COEF_OUT2: coef_out2 <= cfg_data;
        REG_COEF_ERR0: coef_err0 <= cfg_data;
        REG_COEF_ERR1: coef_err1 <= cfg_data;
        REG_COEF_ERR2: coef_err2 <= cfg_data;
        REG_OUT_MIN:   out_min   <= cfg_data;
        REG_OUT_MAX:   out_max   <= cfg_data;
        REG_DEAD_BAND: dead_band <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_meas  <= s_tdata[DATA_W-1:0];
      in_targ  <= s_tdata[2*DATA_W-1:DATA_W];
      in_clear <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev  <= '0;
      err_prev2 <= '0;
      raw_prev  <= '0;
      raw_prev2 <= '0;
    end else if (fire) begin
      if (in_clear) begin
        err_prev  <= '0;
        err_prev2 <= '0;
        raw_prev  <= '0;
        raw_prev2 <= '0;
      end else begin
        err_prev  <= err;
        err_prev2 <= err_prev;
        raw_prev  <= raw_next;
        raw_prev2 <= raw_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && !in_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !in_clear) begin
      drive     <= drive_next;
      raw_value <= raw_next;
      clamped   <= (drive_next != raw_next);
    end
  end

endmodule

`default_nettype wire

@@ tb/discrete_pid_filtered_derivative_core_tb.sv @@
// self-checking testbench for the discrete pid core with filtered derivative
`default_nettype none

module discrete_pid_filtered_derivative_core_tb;
  import dpid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DATA_W-1:0] UNITY   = 32'sd65536;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;
  localparam logic signed [71:0] WIDE_MAX   = 72'sd2147483647;
  localparam logic signed [71:0] WIDE_MIN   = -72'sd2147483648;
  localparam logic signed [71:0] ROUND_HALF = 72'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] raw;
    logic                     clamped;
  } pid_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [DATA_W-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [2*DATA_W-1:0] s_tdata = '0;   // measurement, target
  logic                s_tuser = 1'b0; // clear
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [2*DATA_W-1:0] m_tdata;        // drive, raw_value
  logic                m_tuser;        // clamped

  discrete_pid_filtered_derivative_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [DATA_W-1:0] cfg_model [8] =
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, OUT_MIN_RESET, OUT_MAX_RESET, 32'sd0};
  logic [DATA_W-1:0]        next_cfg [8];
  logic signed [DATA_W-1:0] err_hist1 = '0;
  logic signed [DATA_W-1:0] err_hist2 = '0;
  logic signed [DATA_W-1:0] raw_hist1 = '0;
  logic signed [DATA_W-1:0] raw_hist2 = '0;

  pid_result_t pending_results [$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] v);
    if (v > WIDE_MAX) return S32_MAX;
    if (v < WIDE_MIN) return S32_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic bit step_pid(input logic signed [DATA_W-1:0] meas,
                                  input logic signed [DATA_W-1:0] tgt,
                                  input logic clr, output pid_result_t res);
    logic signed [32:0]       diff;
    logic signed [32:0]       mag;
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] raw;
    logic signed [71:0]       k0, k1, k2, k3, k4, v0, v1, v2, v3, v4, acc;
    res = '0;
    if (clr) begin
      err_hist1 = '0;
      err_hist2 = '0;
      raw_hist1 = '0;
      raw_hist2 = '0;
      return 1'b0;
    end
    diff = $signed({tgt[DATA_W-1], tgt}) - $signed({meas[DATA_W-1], meas});
    mag = (diff < 0) ? -diff : diff;
    if (mag < $signed({2'b00, cfg_model[REG_DEAD_BAND][DB_W-1:0]})) diff = '0;
    err = sat32(diff);
    k0 = cfg_model[REG_COEF_OUT1];  v0 = raw_hist1;
    k1 = cfg_model[REG_COEF_OUT2];  v1 = raw_hist2;
    k2 = cfg_model[REG_COEF_ERR0];  v2 = err;
    k3 = cfg_model[REG_COEF_ERR1];  v3 = err_hist1;
    k4 = cfg_model[REG_COEF_ERR2];  v4 = err_hist2;
    acc = -(k0 * v0) - (k1 * v1) + k2 * v2 + k3 * v3 + k4 * v4;
    // floor after adding half: round to nearest, ties toward plus infinity
    acc = (acc + ROUND_HALF) >>> FRAC_BITS;
    raw = sat32(acc);
    res.raw = raw;
    res.drive = raw;
    if (raw > cfg_model[REG_OUT_MAX]) res.drive = cfg_model[REG_OUT_MAX];
    if (raw < cfg_model[REG_OUT_MIN]) res.drive = cfg_model[REG_OUT_MIN];
    res.clamped = (res.drive != raw);
    err_hist2 = err_hist1;
    err_hist1 = err;
    raw_hist2 = raw_hist1;
    raw_hist1 = raw;
    return 1'b1;
  endfunction

  task automatic send_sample(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] tgt, input logic clr);
    int          gap;
    pid_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tgt, meas};
    s_tuser  <= clr;
    do @(posedge clk); while (!s_tready);
    if (step_pid(meas, tgt, clr, res)) pending_results.push_back(res);
  endtask

  // stop sending and let the core drain, clear transactions included
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_gains(input logic [DATA_W-1:0] c_out1, input logic [DATA_W-1:0] c_out2,
                            input logic [DATA_W-1:0] c_err0, input logic [DATA_W-1:0] c_err1,
                            input logic [DATA_W-1:0] c_err2, input logic [DATA_W-1:0] lo,
                            input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] band);
    quiesce();
    next_cfg[REG_COEF_OUT1] = c_out1;
    next_cfg[REG_COEF_OUT2] = c_out2;
    next_cfg[REG_COEF_ERR0] = c_err0;
    next_cfg[REG_COEF_ERR1] = c_err1;
    next_cfg[REG_COEF_ERR2] = c_err2;
    next_cfg[REG_OUT_MIN]   = lo;
    next_cfg[REG_OUT_MAX]   = hi;
    next_cfg[REG_DEAD_BAND] = band;
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= CFG_AW'(i);
      cfg_data <= next_cfg[i];
      @(posedge clk);
      cfg_model[i] = next_cfg[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2621440)) - 32'd1310720;
      2: begin
        case ($urandom_range(0, 2))
          0: return S32_MAX;
          1: return S32_MIN;
          default: return '0;
        endcase
      end
      default: return 32'($urandom_range(0, 2048)) - 32'd1024;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return S32_MIN;
      2: return '0;
      default: return 32'($urandom_range(0, 262144)) - 32'd131072;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_band();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 32'($urandom_range(0, 262144));
      2: return $urandom;
      default: return 32'h7fffffff;
    endcase
  endfunction

  // receiver side with a fresh stall before every result
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    pid_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: data %h clamped %b",
                                   m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[DATA_W-1:0] !== want.drive || m_tdata[2*DATA_W-1:DATA_W] !== want.raw ||
            m_tuser !== want.clamped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: drive %0d/%0d raw %0d/%0d clamped %b/%b (expected/actual)",
                     want.drive, $signed(m_tdata[DATA_W-1:0]), want.raw,
                     $signed(m_tdata[2*DATA_W-1:DATA_W]), want.clamped, m_tuser);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(S32_MIN, S32_MAX, 1'b0);
    send_sample(32'sd12345, -32'sd98765, 1'b0);
  endtask

  task automatic test_error_path();
    load_gains(0, 0, UNITY, 0, 0, S32_MIN, S32_MAX, 0);
    send_sample(S32_MIN, S32_MAX, 1'b0);
    send_sample(S32_MAX, S32_MIN, 1'b0);
    send_sample(32'sd0, 32'sd0, 1'b0);
    load_gains(0, 0, UNITY, 0, 0, S32_MIN, S32_MAX, UNITY);
    send_sample(32'sd0, UNITY - 1, 1'b0);
    send_sample(32'sd0, UNITY, 1'b0);
    send_sample(32'sd0, -(UNITY - 1), 1'b0);
  endtask

  task automatic test_rounding();
    load_gains(0, 0, 32'd1, 0, 0, S32_MIN, S32_MAX, 0);
    send_sample(32'sd0, 32'sd32768, 1'b0);
    send_sample(32'sd0, -32'sd32768, 1'b0);
    send_sample(32'sd0, -32'sd32769, 1'b0);
    send_sample(32'sd0, 32'sd32767, 1'b0);
  endtask

  task automatic test_clamp();
    load_gains(0, 0, UNITY, 0, 0, OUT_MIN_RESET, OUT_MAX_RESET, 0);
    send_sample(32'sd0, 20 * UNITY, 1'b0);
    send_sample(32'sd0, -20 * UNITY, 1'b0);
    // inverted limits, the minimum limit wins
    load_gains(0, 0, UNITY, 0, 0, 5 * UNITY, -5 * UNITY, 0);
    send_sample(32'sd0, 32'sd0, 1'b0);
  endtask

  task automatic test_history_clear();
    load_gains(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 0);
    send_sample(rand_q16(), rand_q16(), 1'b0);
    send_sample(rand_q16(), rand_q16(), 1'b0);
    send_sample(32'sd3, -32'sd7, 1'b0);
    send_sample($urandom, $urandom, 1'b1);
    send_sample(32'sd0, UNITY, 1'b0);
    send_sample(-UNITY, 32'sd0, 1'b0);
  endtask

  task automatic test_random_phase(input int n_items, input bit hold_off);
    logic signed [DATA_W-1:0] lo, hi, tmp;
    lo = rand_q16();
    hi = rand_q16();
    if ($urandom_range(0, 4) != 0 && lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    load_gains(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), lo, hi,
               rand_band());
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (hold_off && i == n_items / 2) quiesce();
      send_sample(rand_q16(), rand_q16(), $urandom_range(0, 19) == 0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_error_path();
    test_rounding();
    test_clamp();
    test_history_clear();
    for (int p = 0; p < 5; p++) test_random_phase(80, p == 2);
    quiesce();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("discrete_pid_filtered_derivative_core_tb: clean");
    else
      $display("discrete_pid_filtered_derivative_core_tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("discrete_pid_filtered_derivative_core_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
